[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, switched off while reset is high
`define TPSS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked property, also checked during reset
`define TPSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/tpss_pkg.sv]
package tpss_pkg;

   // table geometry
   localparam int NUM_FRAMES = 64;
   localparam int NUM_HARTS  = 4;
   localparam int FRAME_W    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int HART_W     = (NUM_HARTS > 1) ? $clog2(NUM_HARTS) : 1;

   // word field widths
   localparam int FUNC_W = 1;
   localparam int HIDX_W = 2;
   localparam int PID_W  = 8;
   localparam int END_W  = 7;
   localparam int TIME_W = 64;
   localparam int FL_W   = 32;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_SLACK = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME = 1'd1;
   localparam logic [FL_W-1:0] FRAME_LEN_RESET = 32'd1000;

   // word function codes
   localparam logic [FUNC_W-1:0] FUNC_UPDATE = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 1'b1;

   // divider runs one quotient bit per cycle
   localparam int DIV_STEPS = TIME_W;
   localparam int DCNT_W    = $clog2(DIV_STEPS);

   typedef struct packed {
      logic [PID_W-1:0] pid;
      logic [END_W-1:0] end_frame;
   } entry_type;

   typedef entry_type [NUM_HARTS-1:0] row_type;

   localparam logic [END_W-1:0] RESET_END = END_W'(NUM_FRAMES);

   typedef struct packed {
      logic               en;
      logic [FRAME_W-1:0] frame;
      logic [HART_W-1:0]  lane;
      entry_type          entry;
   } tbl_wr_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [FL_W-1:0]    rem;
      logic [FRAME_W-1:0] frame;
   } div_res_type;

endpackage

[design/tpss_divider.sv]
module tpss_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tpss_pkg::TIME_W-1:0] dividend,
   input  logic [tpss_pkg::FL_W-1:0]   divisor,
   output tpss_pkg::div_res_type       res
);
   import tpss_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic [TIME_W-1:0] dvd_ff;
   logic [FL_W-1:0]   dsr_ff;
   logic [FL_W-1:0]   rem_ff;
   logic [FL_W-1:0]   rem_in;
   logic [FRAME_W-1:0] mod_ff;
   logic [FRAME_W-1:0] mod_in;
   logic [FL_W:0]     shifted;
   logic [FL_W:0]     diff;
   logic              qbit;
   logic [FRAME_W:0]  mod2;

   // one restoring step: shift in a dividend bit, compare and subtract
   always_comb begin
      shifted = {rem_ff, dvd_ff[TIME_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      qbit    = (shifted >= {1'b0, dsr_ff});
      rem_in  = qbit ? diff[FL_W-1:0] : shifted[FL_W-1:0];
      // quotient modulo the frame count, tracked as bits arrive
      mod2    = {mod_ff, qbit};
      if (int'(mod2) >= NUM_FRAMES) begin
         mod2 = mod2 - (FRAME_W+1)'(NUM_FRAMES);
      end
      mod_in  = mod2[FRAME_W-1:0];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + DCNT_W'(1);
            if (cnt_ff == DCNT_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
         mod_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[TIME_W-2:0], 1'b0};
         rem_ff <= rem_in;
         mod_ff <= mod_in;
      end
   end

   assign res.busy  = busy_ff;
   assign res.done  = done_ff;
   assign res.rem   = rem_ff;
   assign res.frame = mod_ff;

endmodule

[design/tpss_table.sv]
module tpss_table (
   input  logic                         clock,
   input  logic                         reset,
   input  tpss_pkg::tbl_wr_type         wr,
   input  logic                         rd_en,
   input  logic [tpss_pkg::FRAME_W-1:0] rd_frame,
   output tpss_pkg::row_type            rd_row
);
   import tpss_pkg::*;

   entry_type mem [NUM_FRAMES][NUM_HARTS];
   logic      valid_ff [NUM_FRAMES][NUM_HARTS];
   row_type   rdata_ff;
   logic [NUM_HARTS-1:0] rvld_ff;

   // entry array, one lane written per cycle
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.frame][wr.lane] <= wr.entry;
      end
   end

   // whole row read, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         for (int h = 0; h < NUM_HARTS; h++) begin
            rdata_ff[h] <= mem[rd_frame][h];
         end
      end
   end

   // written flags; an unwritten entry reads as the reset entry
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int f = 0; f < NUM_FRAMES; f++) begin
            for (int h = 0; h < NUM_HARTS; h++) begin
               valid_ff[f][h] <= 1'b0;
            end
         end
         rvld_ff <= '0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.frame][wr.lane] <= 1'b1;
         end
         if (rd_en) begin
            for (int h = 0; h < NUM_HARTS; h++) begin
               rvld_ff[h] <= valid_ff[rd_frame][h];
            end
         end
      end
   end

   always_comb begin
      for (int h = 0; h < NUM_HARTS; h++) begin
         if (rvld_ff[h]) begin
            rd_row[h] = rdata_ff[h];
         end else begin
            rd_row[h].pid       = '0;
            rd_row[h].end_frame = RESET_END;
         end
      end
   end

endmodule

[design/time_partition_slot_scheduler_top.sv]
// channel  | ports                  | moves
// ---------+------------------------+-------------------------------------------
// request  | req_valid / req_ready  | func, hart, proc_id, frames, now
// response | rsp_valid / rsp_ready  | granted, granted_proc, slot_start, slot_end
// config   | csr_we                 | csr_index, csr_wdata, no wait, no read-back
//
// Update word: writes one table frame per cycle, up to NUM_FRAMES frames.
// Query word: its time is divided by the radix-2 divider (one quotient bit a cycle).
// Reset clears all entry flags together; no clearing pass follows.
// A finished word waits in the response register; the next request is taken meanwhile,
// and the sequencer holds its result until that register is free.
module time_partition_slot_scheduler_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tpss_pkg::FUNC_W-1:0]     req_func,
   input  logic [tpss_pkg::HIDX_W-1:0]     req_hart,
   input  logic [tpss_pkg::PID_W-1:0]      req_proc_id,
   input  logic [tpss_pkg::END_W-1:0]      req_end_frame,
   input  logic [tpss_pkg::END_W-1:0]      req_from_frame,
   input  logic [tpss_pkg::END_W-1:0]      req_to_frame,
   input  logic [tpss_pkg::TIME_W-1:0]     req_now,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_granted,
   output logic [tpss_pkg::PID_W-1:0]      rsp_granted_proc,
   output logic [tpss_pkg::TIME_W-1:0]     rsp_slot_start,
   output logic [tpss_pkg::TIME_W-1:0]     rsp_slot_end,
   input  logic                            csr_we,
   input  logic [tpss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tpss_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tpss_pkg::*;

   `include "assert_macros.svh"

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_UPD  = 3'd1;
   localparam logic [2:0] S_ADD  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_READ = 3'd4;
   localparam logic [2:0] S_CHK  = 3'd5;
   localparam logic [2:0] S_SUM  = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   localparam int CMP_W  = ((END_W > FRAME_W) ? END_W : FRAME_W) + 1;
   localparam int PROD_W = CMP_W + FL_W;

   logic [2:0]         state_ff;
   logic [2:0]         state_in;
   logic [FL_W-1:0]    slack_ff;
   logic [FL_W-1:0]    flen_ff;
   logic [FL_W-1:0]    fl_eff;
   logic [TIME_W-1:0]  stamp_ff;

   logic [FUNC_W-1:0]  func_ff;
   logic [HIDX_W-1:0]  hart_ff;
   logic [PID_W-1:0]   pid_ff;
   logic [END_W-1:0]   endf_ff;
   logic [END_W-1:0]   to_ff;
   logic [END_W-1:0]   f_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [TIME_W-1:0]  sum_ff;
   logic [TIME_W-1:0]  sum_in;
   logic               stale_ff;
   logic [FRAME_W-1:0] frame_ff;
   logic [TIME_W-1:0]  start_ff;
   logic [TIME_W-1:0]  end_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic               grant_ff;
   logic [PID_W-1:0]   gpid_ff;

   logic               rsp_valid_ff;
   logic               rsp_granted_ff;
   logic [PID_W-1:0]   rsp_proc_ff;
   logic [TIME_W-1:0]  rsp_start_ff;
   logic [TIME_W-1:0]  rsp_end_ff;

   logic               req_fire;
   logic               hart_ok;
   logic               upd_more;
   logic               out_free;
   logic [HART_W-1:0]  hidx;
   tbl_wr_type         tbl_wr;
   row_type            row;
   div_res_type        div_res;
   entry_type          sel;
   logic               prio;
   logic               chk_ok;
   logic [CMP_W-1:0]   end_x;
   logic [CMP_W-1:0]   frm_x;
   logic [CMP_W-1:0]   len;

   assign req_fire = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign hart_ok  = (int'(hart_ff) < NUM_HARTS);
   assign hidx     = HART_W'(hart_ff);
   assign fl_eff   = (flen_ff == '0) ? FL_W'(1) : flen_ff;
   assign sum_in   = now_ff + TIME_W'(slack_ff);
   assign upd_more = (f_ff < to_ff) && (int'(f_ff) < NUM_FRAMES);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slack_ff <= '0;
         flen_ff  <= FRAME_LEN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SLACK: slack_ff <= csr_wdata;
            CSR_FRAME: flen_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // query divider: (now + slack) / frame length
   tpss_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_ADD),
      .dividend (sum_in),
      .divisor  (fl_eff),
      .res      (div_res)
   );

   // frame table
   always_comb begin
      tbl_wr.en              = (state_ff == S_UPD) && upd_more;
      tbl_wr.frame           = FRAME_W'(f_ff);
      tbl_wr.lane            = hidx;
      tbl_wr.entry.pid       = pid_ff;
      tbl_wr.entry.end_frame = endf_ff;
   end

   tpss_table u_tbl (
      .clock    (clock),
      .reset    (reset),
      .wr       (tbl_wr),
      .rd_en    (state_ff == S_READ),
      .rd_frame (frame_ff),
      .rd_row   (row)
   );

   // slot check on the fetched row
   always_comb begin
      sel  = row[hidx];
      prio = (sel.end_frame != '0);
      for (int i = 0; i < NUM_HARTS; i++) begin
         if (HART_W'(i) != hidx && row[i].pid == sel.pid) begin
            if (HART_W'(i) < hidx && row[i].end_frame >= sel.end_frame) begin
               prio = 1'b0;
            end
            if (HART_W'(i) > hidx && row[i].end_frame > sel.end_frame) begin
               prio = 1'b0;
            end
         end
      end
      end_x  = CMP_W'(sel.end_frame);
      frm_x  = CMP_W'(frame_ff);
      len    = end_x - frm_x;
      chk_ok = hart_ok && !stale_ff && prio && (end_x > frm_x);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = (req_func == FUNC_QUERY) ? S_ADD : S_UPD;
            end
         end
         S_UPD:  if (!hart_ok || !upd_more) state_in = S_DONE;
         S_ADD:  state_in = S_DIV;
         S_DIV:  if (div_res.done) state_in = S_READ;
         S_READ: state_in = S_CHK;
         S_CHK:  state_in = S_SUM;
         S_SUM:  state_in = S_DONE;
         S_DONE: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stamp_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_UPD && hart_ok && !upd_more) begin
            stamp_ff <= now_ff;
         end
      end
   end

   // word datapath
   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff  <= req_func;
         hart_ff  <= req_hart;
         pid_ff   <= req_proc_id;
         endf_ff  <= req_end_frame;
         f_ff     <= req_from_frame;
         to_ff    <= req_to_frame;
         now_ff   <= req_now;
         grant_ff <= 1'b0;
      end
      if (state_ff == S_UPD && upd_more) begin
         f_ff <= f_ff + END_W'(1);
      end
      if (state_ff == S_ADD) begin
         sum_ff   <= sum_in;
         stale_ff <= (now_ff < stamp_ff);
      end
      if (state_ff == S_DIV && div_res.done) begin
         frame_ff <= div_res.frame;
         start_ff <= sum_ff - TIME_W'(div_res.rem);
      end
      if (state_ff == S_CHK) begin
         grant_ff <= chk_ok;
         gpid_ff  <= sel.pid;
         prod_ff  <= PROD_W'(len) * PROD_W'(fl_eff);
      end
      if (state_ff == S_SUM) begin
         end_ff <= start_ff + TIME_W'(prod_ff);
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && out_free) begin
         rsp_granted_ff <= grant_ff;
         rsp_proc_ff    <= grant_ff ? gpid_ff  : '0;
         rsp_start_ff   <= grant_ff ? start_ff : '0;
         rsp_end_ff     <= grant_ff ? end_ff   : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_granted_proc = rsp_proc_ff;
   assign rsp_slot_start   = rsp_start_ff;
   assign rsp_slot_end     = rsp_end_ff;

   `TPSS_ASSERT(a_upd_only_writes, clock, reset,
      tbl_wr.en |-> (func_ff == FUNC_UPDATE),
      "table written outside an update")
   `TPSS_ASSERT(a_div_in_query, clock, reset,
      div_res.busy |-> (state_ff == S_DIV),
      "divider busy outside the divide step")
   `TPSS_ASSERT(a_ungranted_zero, clock, reset,
      (rsp_valid_ff && !rsp_granted_ff) |->
         (rsp_proc_ff == '0 && rsp_start_ff == '0 && rsp_end_ff == '0),
      "ungranted word carries data")
   `TPSS_ASSERT(a_no_overwrite, clock, reset,
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff && $stable(rsp_end_ff),
      "pending response overwritten")

endmodule

[test/slot_checker.sv]
`timescale 1ns / 1ps

// Watches the request, response and register ports of the slot scheduler.
// Keeps its own copy of the frame table, predicts one response word per
// accepted request word and compares responses in order.
module slot_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [tpss_pkg::FUNC_W-1:0]     req_func,
   input  logic [tpss_pkg::HIDX_W-1:0]     req_hart,
   input  logic [tpss_pkg::PID_W-1:0]      req_proc_id,
   input  logic [tpss_pkg::END_W-1:0]      req_end_frame,
   input  logic [tpss_pkg::END_W-1:0]      req_from_frame,
   input  logic [tpss_pkg::END_W-1:0]      req_to_frame,
   input  logic [tpss_pkg::TIME_W-1:0]     req_now,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            rsp_granted,
   input  logic [tpss_pkg::PID_W-1:0]      rsp_granted_proc,
   input  logic [tpss_pkg::TIME_W-1:0]     rsp_slot_start,
   input  logic [tpss_pkg::TIME_W-1:0]     rsp_slot_end,
   input  logic                            csr_we,
   input  logic [tpss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tpss_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              errors,
   output int                              pending
);
   import tpss_pkg::*;

   typedef struct packed {
      logic              granted;
      logic [PID_W-1:0]  proc_id;
      logic [TIME_W-1:0] start_t;
      logic [TIME_W-1:0] stop_t;
   } grant_word_type;

   // shadow of the block's state
   row_type           slot_tbl [NUM_FRAMES];
   logic [TIME_W-1:0] stamp;
   logic [FL_W-1:0]   slack_len;
   logic [FL_W-1:0]   frame_len;
   grant_word_type    grant_q [$];

   function automatic void clear_slots();
      entry_type e;
      e.pid = '0;
      e.end_frame = RESET_END;
      for (int f = 0; f < NUM_FRAMES; f++)
         for (int h = 0; h < NUM_HARTS; h++)
            slot_tbl[f][h] = e;
      stamp = '0;
      slack_len = '0;
      frame_len = FRAME_LEN_RESET;
   endfunction

   // a hart owns its process in this frame unless a sibling holds it longer;
   // ties go to the lower hart
   function automatic bit owns_slot(row_type row, int unsigned h);
      entry_type own;
      own = row[h];
      if (own.end_frame == 0) return 1'b0;
      for (int unsigned i = 0; i < NUM_HARTS; i++) begin
         if (i != h && row[i].pid == own.pid) begin
            if (i < h && row[i].end_frame >= own.end_frame) return 1'b0;
            if (i > h && row[i].end_frame > own.end_frame) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // apply one request word to the shadow table and return its response
   function automatic grant_word_type schedule_word(
      logic [FUNC_W-1:0] func, logic [HIDX_W-1:0] hart, logic [PID_W-1:0] pid,
      logic [END_W-1:0] endf, logic [END_W-1:0] from_f, logic [END_W-1:0] to_f,
      logic [TIME_W-1:0] now);
      grant_word_type    res;
      entry_type         e;
      logic [TIME_W-1:0] fl, quot, span;
      int unsigned       cur;
      res = '0;
      if (func == FUNC_UPDATE) begin
         if (hart < NUM_HARTS) begin
            e.pid = pid;
            e.end_frame = endf;
            for (int unsigned f = from_f; f < to_f && f < NUM_FRAMES; f++)
               slot_tbl[f][hart] = e;
            stamp = now;
         end
         return res;
      end
      // query: zero frame length counts as one
      fl = (frame_len == 0) ? TIME_W'(1) : TIME_W'(frame_len);
      quot = (now + TIME_W'(slack_len)) / fl;
      cur = 32'(quot % TIME_W'(NUM_FRAMES));
      if (hart >= NUM_HARTS || now < stamp) return res;
      e = slot_tbl[cur][hart];
      if (!owns_slot(slot_tbl[cur], hart) || e.end_frame <= cur) return res;
      span = TIME_W'(e.end_frame) - TIME_W'(cur);
      res.granted = 1'b1;
      res.proc_id = e.pid;
      res.start_t = quot * fl;
      res.stop_t = quot * fl + span * fl;
      return res;
   endfunction

   task automatic flag_mismatch(string what, logic [TIME_W-1:0] want,
                                logic [TIME_W-1:0] got);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      errors++;
   endtask

   always @(posedge clock) begin
      grant_word_type want;
      if (reset) begin
         clear_slots();
         grant_q.delete();
         errors = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_SLACK) slack_len = csr_wdata;
            else if (csr_index == CSR_FRAME) frame_len = csr_wdata;
         end
         if (req_valid && req_ready)
            grant_q.push_back(schedule_word(req_func, req_hart, req_proc_id,
               req_end_frame, req_from_frame, req_to_frame, req_now));
         if (rsp_valid && rsp_ready) begin
            if (grant_q.size() == 0) begin
               flag_mismatch("unexpected response word", '0, TIME_W'(rsp_granted));
            end else begin
               want = grant_q.pop_front();
               if (rsp_granted !== want.granted)
                  flag_mismatch("granted", TIME_W'(want.granted), TIME_W'(rsp_granted));
               if (rsp_granted_proc !== want.proc_id)
                  flag_mismatch("granted_proc", TIME_W'(want.proc_id),
                                TIME_W'(rsp_granted_proc));
               if (rsp_slot_start !== want.start_t)
                  flag_mismatch("slot_start", want.start_t, rsp_slot_start);
               if (rsp_slot_end !== want.stop_t)
                  flag_mismatch("slot_end", want.stop_t, rsp_slot_end);
            end
         end
      end
      pending = grant_q.size();
   end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import tpss_pkg::*;

   logic                  clock, reset;
   logic                  req_valid, req_ready;
   logic [FUNC_W-1:0]     req_func;
   logic [HIDX_W-1:0]     req_hart;
   logic [PID_W-1:0]      req_proc_id;
   logic [END_W-1:0]      req_end_frame, req_from_frame, req_to_frame;
   logic [TIME_W-1:0]     req_now;
   logic                  rsp_valid, rsp_ready, rsp_granted;
   logic [PID_W-1:0]      rsp_granted_proc;
   logic [TIME_W-1:0]     rsp_slot_start, rsp_slot_end;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int                mismatches, in_flight;
   bit                steady, hold_rsp;
   logic [TIME_W-1:0] cur_time;

   time_partition_slot_scheduler_top dut (.*);

   slot_checker chk (.*, .errors(mismatches), .pending(in_flight));

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // mostly no gap, some short ones, a few long ones
   function automatic int draw_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // response side: random stalls, plus one long hold-off on request
   initial begin
      int unsigned hold_left;
      int          g;
      hold_left = 0;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_left = 300;
            hold_rsp = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            g = draw_gap();
            if (g == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               hold_left = g - 1;
            end
         end
      end
   end

   task automatic push_word(logic [FUNC_W-1:0] func, logic [HIDX_W-1:0] hart,
                            logic [PID_W-1:0] pid, logic [END_W-1:0] endf,
                            logic [END_W-1:0] from_f, logic [END_W-1:0] to_f,
                            logic [TIME_W-1:0] now);
      @(negedge clock);
      req_valid <= 1'b1;
      req_func <= func;
      req_hart <= hart;
      req_proc_id <= pid;
      req_end_frame <= endf;
      req_from_frame <= from_f;
      req_to_frame <= to_f;
      req_now <= now;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic idle_sender(int n);
      if (n > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic ask(logic [HIDX_W-1:0] hart, logic [TIME_W-1:0] now);
      push_word(FUNC_QUERY, hart, '0, '0, '0, '0, now);
   endtask

   task automatic put(logic [HIDX_W-1:0] hart, logic [PID_W-1:0] pid,
                      logic [END_W-1:0] endf, logic [END_W-1:0] from_f,
                      logic [END_W-1:0] to_f, logic [TIME_W-1:0] now);
      push_word(FUNC_UPDATE, hart, pid, endf, from_f, to_f, now);
   endtask

   // stop offering and wait until every response word is back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (in_flight == 0);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // one random word: updates on the running time base, queries that walk
   // forward through the frames, with some stale and wild times mixed in
   task automatic send_random(logic [TIME_W-1:0] flen);
      int unsigned       r;
      logic [END_W-1:0]  lo, hi, endf;
      logic [PID_W-1:0]  pid;
      logic [TIME_W-1:0] at;
      r = $urandom_range(99);
      if (r < 30) begin
         lo = END_W'($urandom_range(NUM_FRAMES));
         hi = ($urandom_range(99) < 85) ? END_W'($urandom_range(NUM_FRAMES, lo))
                                        : END_W'($urandom_range(NUM_FRAMES));
         pid = ($urandom_range(3) == 0) ? PID_W'($urandom) : PID_W'($urandom_range(3));
         endf = ($urandom_range(9) == 0) ? '0 : END_W'($urandom_range(NUM_FRAMES, 1));
         at = cur_time;
         r = $urandom_range(99);
         if (r < 3) begin
            at = {$urandom, $urandom};
            cur_time = at;
         end else if (r < 13) begin
            at = cur_time - TIME_W'($urandom_range(1000));
         end
         put(HIDX_W'($urandom_range(3)), pid, endf, lo, hi, at);
      end else begin
         cur_time += {$urandom, $urandom} % (2 * flen + 1);
         at = cur_time;
         r = $urandom_range(99);
         if (r < 5) at = cur_time - {$urandom, $urandom} % (2 * flen + 1);
         else if (r < 10) at = {$urandom, $urandom};
         push_word(FUNC_QUERY, HIDX_W'($urandom_range(3)), PID_W'($urandom),
                   END_W'($urandom_range(NUM_FRAMES)), END_W'($urandom_range(NUM_FRAMES)),
                   END_W'($urandom_range(NUM_FRAMES)), at);
      end
      idle_sender(draw_gap());
   endtask

   initial begin
      logic [FL_W-1:0]   sl, fr;
      logic [TIME_W-1:0] flen;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_UPDATE;
      req_hart = '0;
      req_proc_id = '0;
      req_end_frame = '0;
      req_from_frame = '0;
      req_to_frame = '0;
      req_now = '0;
      csr_we = 1'b0;
      csr_index = CSR_SLACK;
      csr_wdata = '0;
      steady = 1'b0;
      hold_rsp = 1'b0;
      cur_time = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed words on the reset table and default registers
      ask(0, 0);
      ask(1, 0);
      ask(3, 63999);
      ask(0, 63999);
      put(2, 8'hFF, 64, 0, 64, 0);
      ask(2, 5000);
      // sibling with a longer slot wins, then a tie goes to the lower hart
      put(1, 8'hFF, 40, 0, 64, 6000);
      ask(1, 7000);
      put(2, 8'hFF, 40, 0, 64, 6000);
      ask(1, 7000);
      ask(2, 7000);
      // delete, then a query older than the table stamp
      put(1, 8'h00, 0, 0, 64, 8000);
      ask(1, 9000);
      ask(2, 9000);
      ask(0, 7999);
      // slot granted before its end frame, then refused at its end frame
      put(0, 8'h07, 10, 0, 64, 9000);
      ask(0, 9500);
      ask(0, 10500);
      // empty range and a range past the table only stamp
      put(3, 8'h09, 20, 30, 20, 11000);
      put(3, 8'h09, 64, 64, 64, 11000);
      ask(0, 64'hFFFF_FFFF_FFFF_FFFF);
      // slack wraps the time, zero frame length acts as one
      drain();
      write_reg(CSR_SLACK, 32'hFFFF_FFFF);
      write_reg(CSR_FRAME, 32'h0);
      ask(0, 64'hFFFF_FFFF_FFFF_FFFF);
      ask(0, 64'hFFFF_FFFF_FFFF_FFF0);
      // widest frame: slot end wraps
      drain();
      write_reg(CSR_SLACK, 32'h0);
      write_reg(CSR_FRAME, 32'hFFFF_FFFF);
      ask(0, 64'hFFFF_FFFF_FFFF_FFFF);

      // random phases, one register setting each
      for (int p = 0; p < 8; p++) begin
         drain();
         case (p)
            0: begin sl = 32'd0; fr = 32'd1000; end
            1: begin sl = 32'd0; fr = 32'd1; end
            2: begin sl = 32'hFFFF_FFFF; fr = 32'hFFFF_FFFF; end
            3: begin sl = 32'd0; fr = 32'd0; end
            4: begin sl = $urandom_range(5000); fr = $urandom_range(5000, 1); end
            5: begin sl = $urandom; fr = $urandom; end
            6: begin sl = 32'd0; fr = 32'd1000; end
            default: begin sl = $urandom; fr = $urandom_range(100000); end
         endcase
         write_reg(CSR_SLACK, sl);
         write_reg(CSR_FRAME, fr);
         steady = (p == 0 || p == 4);
         if (p == 2) cur_time = {32'hFFFF_FFFF, $urandom};
         else if (p == 5) cur_time = {$urandom, $urandom};
         else cur_time = TIME_W'($urandom_range(100000));
         flen = (fr == 0) ? TIME_W'(1) : TIME_W'(fr);
         for (int i = 0; i < 250; i++) begin
            // long response hold-off while words keep coming, later a full pause
            if (p == 6 && i == 20) hold_rsp = 1'b1;
            if (p == 6 && i == 150) drain();
            send_random(flen);
         end
      end

      drain();
      repeat (100) @(posedge clock);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
